/* design/prrs_pkg.sv */
// shared types and constants for the priority round-robin task scheduler
// slot table layout, command and status codes, channel payload structs
// no dependencies
package prrs_pkg;

	localparam int NUM_TASKS = 8;
	localparam int IDX_W     = $clog2(NUM_TASKS);
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	localparam int CMD_W     = 2;
	localparam int PRIO_W    = 8;
	localparam int DELAY_W   = 32;
	localparam int STAT_W    = 2;
	localparam int OUT_IDX_W = 3;

	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELAY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd0;
	localparam logic [STAT_W-1:0] ST_READY   = 2'd1;
	localparam logic [STAT_W-1:0] ST_RUNNING = 2'd2;
	localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [PRIO_W-1:0]  priority_req;
		logic [DELAY_W-1:0] ticks;
	} req_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] running_task;
		logic                 switch_request;
		logic                 no_task_ready;
		logic [OUT_IDX_W-1:0] created_index;
		logic                 table_full;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [STAT_W-1:0]  status;
		logic [DELAY_W-1:0] delay;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] addr;
		slot_t            ent;
	} pick_cand_t;

	typedef struct packed {
		logic             any;
		logic [IDX_W-1:0] win_addr;
		slot_t            win_ent;
	} pick_res_t;

endpackage

/* design/prrs_slot_ram.sv */
// generic single-write, single-read synchronous ram, registered read data
// holds the task slot table; no dependencies
module prrs_slot_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* design/prrs_pick.sv */
// selection accumulator: keeps the best ready slot seen during a sweep
// strict compare in walk order gives round-robin among equal priorities; uses prrs_pkg
module prrs_pick import prrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  pick_cand_t cand,
	output pick_res_t  res
);

	logic             any_q;
	logic [IDX_W-1:0] win_addr_q;
	slot_t            win_ent_q;
	logic             take;

	assign take = cand.valid && (cand.ent.status == ST_READY) &&
		(!any_q || (cand.ent.prio < win_ent_q.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (clear) begin
			any_q <= 1'b0;
		end else if (take) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && take) begin
			win_addr_q <= cand.addr;
			win_ent_q  <= cand.ent;
		end
	end

	assign res.any      = any_q;
	assign res.win_addr = win_addr_q;
	assign res.win_ent  = win_ent_q;

endmodule

/* design/priority_round_robin_task_scheduler.sv */
// top level: priority task scheduler with round-robin among equal priorities
// create and unknown commands complete without a sweep; delay and tick sweep the slot ram
// one request at a time: req_ready is held low until the response is loaded; delay and tick
// do one read-modify-write sweep of the slot ram, one slot per cycle
// reset: async, clears control and fill count; ram is not cleared, slots at and above the
// fill count read as unused; uses prrs_pkg, prrs_slot_ram, prrs_pick
module priority_round_robin_task_scheduler import prrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_LAST  = 3'd2;
	localparam logic [2:0] S_WIN   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

	logic [2:0]         state_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [DELAY_W-1:0] ticks_q;
	logic [IDX_W-1:0]   cur_q;
	logic [CNT_W-1:0]   used_q;
	logic [IDX_W-1:0]   addr_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               rd_valid_s1;
	logic [IDX_W-1:0]   rd_addr_s1;
	logic               sw_q;
	logic               idle_q;
	logic [IDX_W-1:0]   created_q;
	logic               full_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               rsp_load;
	logic               full_now;
	logic [IDX_W-1:0]   start_addr;
	logic [IDX_W-1:0]   next_addr;
	logic               in_use_s1;
	slot_t              old_ent;
	slot_t              new_ent;
	logic [DELAY_W-1:0] dly_dec;
	logic               is_cur;
	logic               pick_clear;
	pick_cand_t         cand;
	pick_res_t          pres;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [SLOT_W-1:0]  ram_wdata;
	logic [SLOT_W-1:0]  ram_rdata;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign rsp_load   = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign full_now   = (used_q == CNT_W'(NUM_TASKS));
	assign start_addr = (cur_q == LAST_IDX) ? '0 : cur_q + IDX_W'(1);
	assign next_addr  = (addr_q == LAST_IDX) ? '0 : addr_q + IDX_W'(1);

	// read-modify of the slot returning from the ram
	assign in_use_s1 = (CNT_W'(rd_addr_s1) < used_q);
	assign old_ent   = in_use_s1 ? slot_t'(ram_rdata) : '0;
	assign is_cur    = (rd_addr_s1 == cur_q);
	assign dly_dec   = (old_ent.delay != '0) ? old_ent.delay - DELAY_W'(1) : old_ent.delay;

	always_comb begin
		new_ent = old_ent;
		unique case (cmd_q)
			CMD_DELAY: begin
				if (is_cur && old_ent.status != ST_UNUSED) begin
					new_ent.delay  = ticks_q;
					new_ent.status = ST_BLOCKED;
				end
			end
			CMD_TICK: begin
				new_ent.delay = dly_dec;
				if (old_ent.status == ST_BLOCKED && dly_dec == '0) begin
					new_ent.status = ST_READY;
				end
				if (is_cur && old_ent.status == ST_RUNNING) begin
					new_ent.status = ST_READY;
				end
			end
			default: begin
				new_ent = old_ent;
			end
		endcase
	end

	assign pick_clear = accept;
	assign cand.valid = rd_valid_s1;
	assign cand.addr  = rd_addr_s1;
	assign cand.ent   = new_ent;

	prrs_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (pick_clear),
		.cand   (cand),
		.res    (pres)
	);

	// single write port: create at transfer, sweep write-back, winner update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = SLOT_W'(new_ent);
		priority if (accept && req.cmd == CMD_CREATE && !full_now) begin
			ram_we    = 1'b1;
			ram_waddr = IDX_W'(used_q);
			ram_wdata = SLOT_W'({req.priority_req, ST_READY, DELAY_W'(0)});
		end else if (rd_valid_s1) begin
			ram_we    = in_use_s1;
			ram_waddr = rd_addr_s1;
			ram_wdata = SLOT_W'(new_ent);
		end else if (state_q == S_WIN && pres.any) begin
			ram_we    = 1'b1;
			ram_waddr = pres.win_addr;
			ram_wdata = SLOT_W'({pres.win_ent.prio, ST_RUNNING, pres.win_ent.delay});
		end else begin
			ram_we    = 1'b0;
		end
	end

	prrs_slot_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (NUM_TASKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			used_q      <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SWEEP);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_DELAY || req.cmd == CMD_TICK) begin
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_DONE;
						end
						if (req.cmd == CMD_CREATE && !full_now) begin
							used_q <= used_q + CNT_W'(1);
						end
					end
				end
				S_SWEEP: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_WIN;
				end
				S_WIN: begin
					cur_q   <= pres.any ? pres.win_addr : '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q;
		if (accept) begin
			cmd_q     <= req.cmd;
			ticks_q   <= req.ticks;
			addr_q    <= start_addr;
			cnt_q     <= '0;
			sw_q      <= 1'b0;
			idle_q    <= 1'b0;
			full_q    <= (req.cmd == CMD_CREATE) && full_now;
			created_q <= (req.cmd == CMD_CREATE && !full_now) ? IDX_W'(used_q) : '0;
		end else if (state_q == S_SWEEP) begin
			addr_q <= next_addr;
			cnt_q  <= cnt_q + IDX_W'(1);
		end
		if (state_q == S_WIN) begin
			sw_q   <= pres.any ? (pres.win_addr != cur_q) : (cur_q != '0);
			idle_q <= !pres.any;
		end
		if (rsp_load) begin
			rsp_q.running_task   <= OUT_IDX_W'(cur_q);
			rsp_q.switch_request <= sw_q;
			rsp_q.no_task_ready  <= idle_q;
			rsp_q.created_index  <= OUT_IDX_W'(created_q);
			rsp_q.table_full     <= full_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
